// ===== design/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock package
// Shared constants, codes and transaction types of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam int CODE_LENGTH = 4;
	localparam int BUF_W       = 8 * CODE_LENGTH;
	localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
	localparam int SH_W        = $clog2(BUF_W);
	localparam int Q_DEPTH     = 2;

	localparam logic [2:0] MODE_OPEN    = 3'd0;
	localparam logic [2:0] MODE_CLOSING = 3'd1;
	localparam logic [2:0] MODE_CLOSED  = 3'd2;
	localparam logic [2:0] MODE_OPENING = 3'd3;
	localparam logic [2:0] MODE_LOCKED  = 3'd4;

	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_MOTOR  = 2'd1;
	localparam logic [1:0] KIND_BUTTON = 2'd2;

	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_KEY     = 3'd1;
	localparam logic [2:0] OP_CONFIRM = 3'd2;
	localparam logic [2:0] OP_MOTOR   = 3'd3;
	localparam logic [2:0] OP_BUTTON  = 3'd4;

	localparam logic [7:0]  KEY_CONFIRM = 8'd35;
	localparam logic [13:0] CLOSE_STEPS = 14'd8192;
	localparam logic [13:0] OPEN_STEPS  = 14'd4096;
	localparam logic [13:0] NO_STEPS    = 14'd0;

	localparam logic [1:0] MOTOR_NONE  = 2'd0;
	localparam logic [1:0] MOTOR_CLOSE = 2'd1;
	localparam logic [1:0] MOTOR_OPEN  = 2'd2;

	localparam logic REG_MASTER_CODE  = 1'b0;
	localparam logic REG_MAX_FAILURES = 1'b1;

	localparam logic [31:0] MASTER_CODE_RESET  = 32'h3132_3334;
	localparam logic [3:0]  MAX_FAILURES_RESET = 4'd3;
	localparam logic [3:0]  FAIL_SATURATE      = 4'd15;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key_code;
	} item_t;

	typedef struct packed {
		logic [2:0]  safe_mode;
		logic [1:0]  motor_start;
		logic [13:0] motor_steps;
		logic [2:0]  keys_entered;
		logic [31:0] entry_shown;
		logic        alarm_led;
		logic        master_entry_active;
		logic        code_rejected;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] key;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

endpackage

// ===== design/kcl_front.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock front end
// Accepts input transactions, classifies them into commands and holds them
// in a two-entry command queue for the execution stage.
// ----------------------------------------------------------------------------
module kcl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  kcl_pkg::item_t     item,
	output kcl_pkg::cmd_link_t link,
	input  logic               take
);

	kcl_pkg::cmd_t cmd_in;
	kcl_pkg::cmd_t queue_q [kcl_pkg::Q_DEPTH];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		cmd_in.key = item.key_code;
		case (item.kind)
			kcl_pkg::KIND_KEY: begin
				cmd_in.op = (item.key_code == kcl_pkg::KEY_CONFIRM) ?
					kcl_pkg::OP_CONFIRM : kcl_pkg::OP_KEY;
			end
			kcl_pkg::KIND_MOTOR:  cmd_in.op = kcl_pkg::OP_MOTOR;
			kcl_pkg::KIND_BUTTON: cmd_in.op = kcl_pkg::OP_BUTTON;
			default:              cmd_in.op = kcl_pkg::OP_NONE;
		endcase
	end

	assign full       = (count_q == 2'(kcl_pkg::Q_DEPTH));
	assign do_push    = push && !full;
	assign do_pop     = take && (count_q != 2'd0);
	assign link.valid = (count_q != 2'd0);
	assign link.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(kcl_pkg::Q_DEPTH))
		else $error("command queue count out of range");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> link.valid)
		else $error("accepted transaction not visible to the execution stage");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !take) |=> full)
		else $error("command queue left full state without a take");
`endif

endmodule

// ===== design/kcl_back.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock execution stage
// Holds the lock state and configuration and does one command per cycle while
// the two-entry result queue, which takes each result, has room or is popped.
// ----------------------------------------------------------------------------
module kcl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  kcl_pkg::cmd_link_t link,
	output logic               take,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               empty,
	input  logic               pop,
	output kcl_pkg::result_t   result
);

	logic [31:0]                master_q;
	logic [3:0]                 max_fail_q;
	logic [2:0]                 mode_q, mode_d;
	logic [kcl_pkg::BUF_W-1:0]  user_q, user_d;
	logic [kcl_pkg::BUF_W-1:0]  buf_q, buf_d;
	logic [kcl_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic [3:0]                 fail_q, fail_d;
	logic                       mentry_q, mentry_d;
	logic [1:0]                 motor;
	logic [13:0]                steps;
	logic                       rejected;
	logic                       buf_full;
	logic [kcl_pkg::SH_W-1:0]   shift;
	logic [kcl_pkg::BUF_W-1:0]  buf_pushed;
	logic [kcl_pkg::CNT_W-1:0]  cnt_pushed;
	logic [63:0]                buf_wide;
	kcl_pkg::result_t           res_in;
	kcl_pkg::result_t           rq_q [kcl_pkg::Q_DEPTH];
	logic                       rq_wr_q;
	logic                       rq_rd_q;
	logic [1:0]                 rq_count_q;
	logic                       do_pop;
	logic [2:0]                 op;

	assign op       = link.cmd.op;
	assign buf_full = (cnt_q == kcl_pkg::CNT_W'(kcl_pkg::CODE_LENGTH));
	assign shift    = kcl_pkg::SH_W'({kcl_pkg::CNT_W'(kcl_pkg::CODE_LENGTH - 1) - cnt_q, 3'b000});
	assign buf_pushed = buf_full ? buf_q :
		(buf_q | (kcl_pkg::BUF_W'(link.cmd.key) << shift));
	assign cnt_pushed = buf_full ? cnt_q : cnt_q + kcl_pkg::CNT_W'(1);

	always_comb begin
		mode_d   = mode_q;
		user_d   = user_q;
		buf_d    = buf_q;
		cnt_d    = cnt_q;
		fail_d   = fail_q;
		mentry_d = mentry_q;
		motor    = kcl_pkg::MOTOR_NONE;
		steps    = kcl_pkg::NO_STEPS;
		rejected = 1'b0;
		case (mode_q)
			kcl_pkg::MODE_OPEN: begin
				if (op == kcl_pkg::OP_KEY) begin
					buf_d = buf_pushed;
					cnt_d = cnt_pushed;
				end else if (op == kcl_pkg::OP_CONFIRM && buf_full) begin
					user_d = buf_q;
					buf_d  = '0;
					cnt_d  = '0;
					mode_d = kcl_pkg::MODE_CLOSING;
					motor  = kcl_pkg::MOTOR_CLOSE;
					steps  = kcl_pkg::CLOSE_STEPS;
				end
			end
			kcl_pkg::MODE_CLOSING: begin
				if (op == kcl_pkg::OP_MOTOR) begin
					mode_d = kcl_pkg::MODE_CLOSED;
					fail_d = 4'd0;
					buf_d  = '0;
					cnt_d  = '0;
				end
			end
			kcl_pkg::MODE_CLOSED: begin
				if (op == kcl_pkg::OP_KEY) begin
					buf_d = buf_pushed;
					cnt_d = cnt_pushed;
				end else if (op == kcl_pkg::OP_CONFIRM && buf_full) begin
					buf_d = '0;
					cnt_d = '0;
					if (buf_q == user_q) begin
						mode_d = kcl_pkg::MODE_OPENING;
						motor  = kcl_pkg::MOTOR_OPEN;
						steps  = kcl_pkg::OPEN_STEPS;
					end else begin
						rejected = 1'b1;
						if (fail_q < kcl_pkg::FAIL_SATURATE) begin
							fail_d = fail_q + 4'd1;
						end
						if (fail_d >= max_fail_q) begin
							mode_d   = kcl_pkg::MODE_LOCKED;
							mentry_d = 1'b0;
						end
					end
				end
			end
			kcl_pkg::MODE_OPENING: begin
				if (op == kcl_pkg::OP_MOTOR) begin
					mode_d = kcl_pkg::MODE_OPEN;
					buf_d  = '0;
					cnt_d  = '0;
				end
			end
			kcl_pkg::MODE_LOCKED: begin
				if (!mentry_q) begin
					if (op == kcl_pkg::OP_BUTTON) begin
						mentry_d = 1'b1;
						buf_d    = '0;
						cnt_d    = '0;
					end
				end else if (op == kcl_pkg::OP_KEY || op == kcl_pkg::OP_CONFIRM) begin
					if (!buf_full) begin
						buf_d = buf_pushed;
						cnt_d = cnt_pushed;
					end else if (op == kcl_pkg::OP_CONFIRM) begin
						mentry_d = 1'b0;
						if (64'(buf_q) == 64'(master_q)) begin
							mode_d = kcl_pkg::MODE_OPENING;
							motor  = kcl_pkg::MOTOR_OPEN;
							steps  = kcl_pkg::OPEN_STEPS;
						end else begin
							rejected = 1'b1;
						end
						buf_d = '0;
						cnt_d = '0;
					end
				end
			end
			default: begin
				mode_d = kcl_pkg::MODE_OPEN;
			end
		endcase
	end

	assign buf_wide = 64'(buf_d);

	always_comb begin
		res_in.safe_mode           = mode_d;
		res_in.motor_start         = motor;
		res_in.motor_steps         = steps;
		res_in.keys_entered        = 3'(cnt_d);
		res_in.entry_shown         = buf_wide[31:0];
		res_in.alarm_led           = (mode_d == kcl_pkg::MODE_LOCKED);
		res_in.master_entry_active = mentry_d;
		res_in.code_rejected       = rejected;
	end

	assign empty  = (rq_count_q == 2'd0);
	assign do_pop = pop && !empty;
	assign take   = link.valid && ((rq_count_q != 2'(kcl_pkg::Q_DEPTH)) || do_pop);
	assign result = rq_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (take) begin
			rq_q[rq_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q   <= kcl_pkg::MASTER_CODE_RESET;
			max_fail_q <= kcl_pkg::MAX_FAILURES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::REG_MASTER_CODE:  master_q   <= cfg_data;
				kcl_pkg::REG_MAX_FAILURES: max_fail_q <= cfg_data[3:0];
				default:                   master_q   <= master_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= kcl_pkg::MODE_OPEN;
			user_q     <= '0;
			buf_q      <= '0;
			cnt_q      <= '0;
			fail_q     <= 4'd0;
			mentry_q   <= 1'b0;
			rq_wr_q    <= 1'b0;
			rq_rd_q    <= 1'b0;
			rq_count_q <= 2'd0;
		end else begin
			if (take) begin
				mode_q   <= mode_d;
				user_q   <= user_d;
				buf_q    <= buf_d;
				cnt_q    <= cnt_d;
				fail_q   <= fail_d;
				mentry_q <= mentry_d;
				rq_wr_q  <= !rq_wr_q;
			end
			if (do_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			case ({take, do_pop})
				2'b10:   rq_count_q <= rq_count_q + 2'd1;
				2'b01:   rq_count_q <= rq_count_q - 2'd1;
				default: rq_count_q <= rq_count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_master_only_locked: assert property (@(posedge clk) disable iff (!arst_n)
		mentry_q |-> (mode_q == kcl_pkg::MODE_LOCKED))
		else $error("master entry active outside locked mode");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= kcl_pkg::CNT_W'(kcl_pkg::CODE_LENGTH))
		else $error("entry count exceeds code length");

	a_close_done: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_q == kcl_pkg::MODE_CLOSING && op == kcl_pkg::OP_MOTOR)
		|=> (mode_q == kcl_pkg::MODE_CLOSED && fail_q == 4'd0))
		else $error("closing motion done did not enter closed mode");
`endif

endmodule

// ===== design/keypad_code_lock_controller.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller
// Safe lock controller with user code, failure lockout and master unlock.
// ----------------------------------------------------------------------------
// Each input transaction (key press, motor done or unlock button) yields
// exactly one result transaction. The block takes one transaction per cycle
// unless the command queue is full; that two-entry queue feeds the execution
// stage, which updates the lock state and writes a two-entry result queue, so
// a result passes both queues before it is visible. The execution stage moves
// one command per cycle whenever the result queue has room or is being popped
// in the same cycle. Configuration registers (master code at index 0, failure
// limit at index 1) are written through cfg_we, cfg_index and cfg_data; the
// user must do so only while no transaction is in flight; nothing enforces it.
module keypad_code_lock_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  kcl_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output kcl_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);

	kcl_pkg::cmd_link_t link;
	logic               take;

	kcl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.link   (link),
		.take   (take)
	);

	kcl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link),
		.take      (take),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== sim/keypad_code_lock_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Keypad code lock controller testbench
// Drives key, motor and button transactions into the lock and checks every
// result against a cycle-free model of the safe: user code setup, closing,
// code checks with lockout, master unlock and the ignored stray events. A
// short directed sequence comes first. Random phases follow, each under its
// own master code, failure limit and mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_tb;
	import kcl_pkg::*;

	localparam logic [1:0] KIND_RESERVED  = 2'd3;
	localparam int         PHASES         = 8;
	localparam int         PHASE_ITEMS    = 144;
	localparam int         NOISE_PCT      = 12;
	localparam int         WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]       mode;
		logic [BUF_W-1:0] user_code;
		logic [BUF_W-1:0] entry;
		logic [CNT_W-1:0] count;
		logic [3:0]       fails;
		logic             master;
	} lock_state_t;

	typedef struct packed {
		logic [31:0] master_code;
		logic [3:0]  max_failures;
	} lock_cfg_t;

	typedef struct packed {
		lock_state_t st;
		result_t     res;
	} lock_step_t;

	typedef struct packed {
		item_t it;
		logic  drain;
	} backlog_entry_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	item_t       item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	result_t     result;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = '0;

	backlog_entry_t input_backlog[$];
	result_t        predicted_results[$];
	lock_state_t    lock_model;
	lock_state_t    plan_lock;
	lock_cfg_t      lock_cfg;
	lock_step_t     accepted;
	backlog_entry_t next_in;
	logic [31:0]    attempt_code;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int planned_items  = 0;
	int errors         = 0;
	int quiet_cycles   = 0;
	int n_items        = 0;
	int n_results      = 0;
	int n_rejects      = 0;
	int n_lockouts     = 0;
	int n_openings     = 0;
	int n_master_opens = 0;

	keypad_code_lock_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic lock_state_t add_key(lock_state_t s, logic [7:0] key);
		if (s.count < CODE_LENGTH) begin
			s.entry = s.entry | (BUF_W'(key) << (8 * (CODE_LENGTH - 1 - int'(s.count))));
			s.count = s.count + 1'b1;
		end
		return s;
	endfunction

	function automatic lock_step_t next_lock(lock_state_t s, lock_cfg_t c, item_t it);
		lock_step_t  r;
		logic        full_buf;
		logic [1:0]  motor;
		logic [13:0] steps;
		logic        rejected;
		full_buf = s.count >= CODE_LENGTH;
		motor    = MOTOR_NONE;
		steps    = NO_STEPS;
		rejected = 1'b0;
		case (s.mode)
			MODE_OPEN: begin
				if (it.kind == KIND_KEY) begin
					if (it.key_code != KEY_CONFIRM) begin
						s = add_key(s, it.key_code);
					end else if (full_buf) begin
						s.user_code = s.entry;
						s.entry     = '0;
						s.count     = '0;
						s.mode      = MODE_CLOSING;
						motor       = MOTOR_CLOSE;
						steps       = CLOSE_STEPS;
					end
				end
			end
			MODE_CLOSING: begin
				if (it.kind == KIND_MOTOR) begin
					s.mode  = MODE_CLOSED;
					s.fails = '0;
					s.entry = '0;
					s.count = '0;
				end
			end
			MODE_CLOSED: begin
				if (it.kind == KIND_KEY) begin
					if (it.key_code != KEY_CONFIRM) begin
						s = add_key(s, it.key_code);
					end else if (full_buf) begin
						if (s.entry == s.user_code) begin
							s.mode = MODE_OPENING;
							motor  = MOTOR_OPEN;
							steps  = OPEN_STEPS;
						end else begin
							rejected = 1'b1;
							if (s.fails < FAIL_SATURATE)
								s.fails = s.fails + 4'd1;
							if (s.fails >= c.max_failures) begin
								s.mode   = MODE_LOCKED;
								s.master = 1'b0;
							end
						end
						s.entry = '0;
						s.count = '0;
					end
				end
			end
			MODE_OPENING: begin
				if (it.kind == KIND_MOTOR) begin
					s.mode  = MODE_OPEN;
					s.entry = '0;
					s.count = '0;
				end
			end
			MODE_LOCKED: begin
				if (!s.master) begin
					if (it.kind == KIND_BUTTON) begin
						s.master = 1'b1;
						s.entry  = '0;
						s.count  = '0;
					end
				end else if (it.kind == KIND_KEY) begin
					if (!full_buf) begin
						s = add_key(s, it.key_code);
					end else if (it.key_code == KEY_CONFIRM) begin
						s.master = 1'b0;
						if (s.entry == c.master_code) begin
							s.mode = MODE_OPENING;
							motor  = MOTOR_OPEN;
							steps  = OPEN_STEPS;
						end else begin
							rejected = 1'b1;
						end
						s.entry = '0;
						s.count = '0;
					end
				end
			end
			default: begin
				s.mode = MODE_OPEN;
			end
		endcase
		r.st                      = s;
		r.res.safe_mode           = s.mode;
		r.res.motor_start         = motor;
		r.res.motor_steps         = steps;
		r.res.keys_entered        = s.count;
		r.res.entry_shown         = s.entry;
		r.res.alarm_led           = s.mode == MODE_LOCKED;
		r.res.master_entry_active = s.master;
		r.res.code_rejected       = rejected;
		return r;
	endfunction

	function automatic logic [7:0] rand_key();
		logic [7:0] k;
		if ($urandom_range(1) == 0)
			return 8'h30 + 8'($urandom_range(9));
		do
			k = 8'($urandom_range(255));
		while (k == KEY_CONFIRM);
		return k;
	endfunction

	task automatic add_item(input logic [1:0] kind, input logic [7:0] key, input logic drain);
		backlog_entry_t e;
		lock_step_t     s;
		e.it.kind     = kind;
		e.it.key_code = key;
		e.drain       = drain;
		s = next_lock(plan_lock, lock_cfg, e.it);
		planned_items++;
		plan_lock = s.st;
		input_backlog.push_back(e);
	endtask

	// Mostly well-formed sequences so that every mode is reached, with some
	// random noise mixed in.
	task automatic pick_item(output logic [1:0] kind, output logic [7:0] key);
		int b;
		kind = KIND_KEY;
		key  = rand_key();
		if ($urandom_range(99) < NOISE_PCT) begin
			kind = 2'($urandom_range(3));
			key  = ($urandom_range(3) == 0) ? KEY_CONFIRM : 8'($urandom_range(255));
		end else begin
			case (plan_lock.mode)
				MODE_OPEN: begin
					if (plan_lock.count >= CODE_LENGTH)
						key = KEY_CONFIRM;
				end
				MODE_CLOSED: begin
					if (plan_lock.count == 0) begin
						if ($urandom_range(1) == 0) begin
							attempt_code = plan_lock.user_code;
						end else begin
							for (b = 0; b < CODE_LENGTH; b++)
								attempt_code[8*b +: 8] = rand_key();
						end
					end
					if (plan_lock.count >= CODE_LENGTH)
						key = KEY_CONFIRM;
					else
						key = 8'(attempt_code >> (8 * (CODE_LENGTH - 1 - int'(plan_lock.count))));
				end
				MODE_LOCKED: begin
					if (!plan_lock.master) begin
						kind = KIND_BUTTON;
					end else begin
						if (plan_lock.count == 0)
							attempt_code = ($urandom_range(1) == 0) ? lock_cfg.master_code
								: 32'($urandom);
						if (plan_lock.count >= CODE_LENGTH)
							key = KEY_CONFIRM;
						else
							key = 8'(attempt_code >> (8 * (CODE_LENGTH - 1 - int'(plan_lock.count))));
					end
				end
				default: begin
					kind = KIND_MOTOR;
				end
			endcase
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (input_backlog.size() != 0 || push || predicted_results.size() != 0);
	endtask

	task automatic report_error(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Driver: presents backlog entries and predicts each accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				accepted = next_lock(lock_model, lock_cfg, item);
				predicted_results.push_back(accepted.res);
				n_items++;
				if (accepted.res.code_rejected)
					n_rejects++;
				if (accepted.st.mode == MODE_LOCKED && lock_model.mode != MODE_LOCKED)
					n_lockouts++;
				if (accepted.res.motor_start == MOTOR_OPEN) begin
					n_openings++;
					if (lock_model.mode == MODE_LOCKED)
						n_master_opens++;
				end
				lock_model = accepted.st;
			end
			if (!push || !full) begin
				if (input_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(input_backlog[0].drain && predicted_results.size() != 0)) begin
					next_in = input_backlog.pop_front();
					item <= next_in.it;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: pops results with random stalls and checks them in order.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_results++;
				if (predicted_results.size() == 0) begin
					report_error("result transaction arrived with none outstanding");
				end else begin
					want = predicted_results.pop_front();
					check_field("safe_mode", result.safe_mode, want.safe_mode);
					check_field("motor_start", result.motor_start, want.motor_start);
					check_field("motor_steps", result.motor_steps, want.motor_steps);
					check_field("keys_entered", result.keys_entered, want.keys_entered);
					check_field("entry_shown", result.entry_shown, want.entry_shown);
					check_field("alarm_led", result.alarm_led, want.alarm_led);
					check_field("master_entry_active", result.master_entry_active,
						want.master_entry_active);
					check_field("code_rejected", result.code_rejected, want.code_rejected);
				end
			end
			pop <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
			$display("keypad_code_lock_controller test failed");
			$finish;
		end
	end

	initial begin
		int          ph;
		int          b;
		int          drain_at;
		int          phase_start;
		logic [1:0]  kind;
		logic [7:0]  key;
		logic [31:0] mc;
		logic [3:0]  mf;
		lock_model      = '0;
		lock_model.mode = MODE_OPEN;
		plan_lock       = lock_model;
		lock_cfg.master_code  = MASTER_CODE_RESET;
		lock_cfg.max_failures = MAX_FAILURES_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// With a failure limit of one, a single wrong code locks the safe.
		write_reg(REG_MAX_FAILURES, 32'd1);
		lock_cfg.max_failures = 4'd1;
		add_item(KIND_RESERVED, 8'hFF, 1'b0);
		add_item(KIND_MOTOR, 8'hAA, 1'b0);
		add_item(KIND_BUTTON, 8'h55, 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);
		add_item(KIND_KEY, 8'h00, 1'b0);
		add_item(KIND_KEY, 8'hFF, 1'b0);
		add_item(KIND_KEY, 8'h80, 1'b0);
		add_item(KIND_KEY, 8'h7F, 1'b0);
		add_item(KIND_KEY, "1", 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);
		add_item(KIND_KEY, "2", 1'b0);
		add_item(KIND_MOTOR, 8'h00, 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);
		add_item(KIND_KEY, "1", 1'b0);
		add_item(KIND_KEY, "2", 1'b0);
		add_item(KIND_KEY, "3", 1'b0);
		add_item(KIND_KEY, "4", 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);
		add_item(KIND_KEY, "9", 1'b0);
		add_item(KIND_MOTOR, 8'h01, 1'b0);
		add_item(KIND_BUTTON, 8'h00, 1'b0);
		add_item(KIND_BUTTON, 8'hFF, 1'b0);
		add_item(KIND_KEY, "1", 1'b0);
		add_item(KIND_KEY, "2", 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);
		add_item(KIND_KEY, "4", 1'b0);
		add_item(KIND_KEY, KEY_CONFIRM, 1'b0);

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			repeat (4) @(posedge clk);
			case (ph)
				0: begin
					mc = MASTER_CODE_RESET;
					mf = MAX_FAILURES_RESET;
				end
				1: begin
					mc = 32'h0000_0000;
					mf = 4'd1;
				end
				2: begin
					mc = 32'hFFFF_FFFF;
					mf = 4'd15;
				end
				3: begin
					mc = {CODE_LENGTH{KEY_CONFIRM}};
					mf = 4'd2;
				end
				5, 6: begin
					for (b = 0; b < CODE_LENGTH; b++)
						mc[8*b +: 8] = 8'h30 + 8'($urandom_range(9));
					mf = (ph == 5) ? 4'd15 : 4'd1;
				end
				default: begin
					mc = 32'($urandom);
					mf = 4'($urandom_range(15, 1));
				end
			endcase
			write_reg(REG_MASTER_CODE, mc);
			write_reg(REG_MAX_FAILURES, {28'd0, mf});
			lock_cfg.master_code  = mc;
			lock_cfg.max_failures = mf;
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 57;
				end
				default: begin
					send_idle_pct  = 25;
					recv_stall_pct = 25;
				end
			endcase
			drain_at    = $urandom_range(PHASE_ITEMS - 1, 1);
			phase_start = planned_items;
			while (planned_items - phase_start < PHASE_ITEMS) begin
				pick_item(kind, key);
				add_item(kind, key, planned_items - phase_start == drain_at);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d transactions and %0d results over %0d register settings",
			n_items, n_results, PHASES + 1);
		$display("Saw %0d wrong codes, %0d lockouts, %0d openings (%0d by master code)",
			n_rejects, n_lockouts, n_openings, n_master_opens);
		if (errors == 0)
			$display("keypad_code_lock_controller test passed");
		else
			$display("keypad_code_lock_controller test failed");
		$finish;
	end

endmodule
